// File: rtl/wsps_pkg.sv
// ----------------------------------------------------------------------------
// wsps_pkg: shared types and constants for the wildcard pattern search
// Character codes, status codes, register indexes and the configuration
// bundle passed from the top level to the matcher.
// ----------------------------------------------------------------------------
package wsps_pkg;

  // Pattern characters with special meaning
  localparam logic [7:0] CH_WILD = 8'h3F;  // '?' matches any byte past position 0
  localparam logic [7:0] CH_LF   = 8'h0A;  // '\n' also matches CR LF
  localparam logic [7:0] CH_CR   = 8'h0D;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_PATTERN_CHARS  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } reg_index_t;

  // Per-word status
  typedef enum logic [1:0] {
    STATUS_SEARCHING = 2'd0,
    STATUS_MATCHED   = 2'd1,
    STATUS_END       = 2'd2
  } status_t;

  // Pattern configuration
  typedef struct packed {
    logic [63:0] chars;
    logic [3:0]  length;
  } pattern_cfg_t;

endpackage

// File: rtl/wsps_matcher.sv
// ----------------------------------------------------------------------------
// wsps_matcher: match state and next-state logic
// Holds the match position and the pending-CR flag, and computes the status
// of one stream word. The state advances only when step is high.
// ----------------------------------------------------------------------------
module wsps_matcher #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  is_end,
  input  wsps_pkg::pattern_cfg_t cfg,
  output wsps_pkg::status_t     status
);

  localparam int POS_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [POS_W-1:0] match_position;
  logic [POS_W-1:0] match_position_next;
  logic             cr_pending;
  logic             cr_pending_next;

  logic [3:0]       len_eff;
  logic [3:0]       pos_wide;
  logic [POS_W-1:0] pos_cur;
  logic             cr_cur;
  logic [7:0]       pat_char;
  logic [3:0]       pos_inc;
  logic             advance;

  // Clamp the configured length to 1..MAX_PATTERN
  always_comb begin
    if (cfg.length == 4'd0) begin
      len_eff = 4'd1;
    end else if (cfg.length > 4'(MAX_PATTERN)) begin
      len_eff = 4'(MAX_PATTERN);
    end else begin
      len_eff = cfg.length;
    end
  end

  // Re-arm when a shortened pattern leaves the position out of range
  assign pos_wide = 4'(match_position);
  assign pos_cur  = (pos_wide >= len_eff) ? '0 : match_position;
  assign cr_cur   = (pos_wide >= len_eff) ? 1'b0 : cr_pending;
  assign pat_char = cfg.chars[{pos_cur, 3'b000} +: 8];
  assign pos_inc  = 4'(pos_cur) + 4'd1;

  // Compare the word and pick the next state
  always_comb begin
    status              = wsps_pkg::STATUS_SEARCHING;
    advance             = 1'b0;
    match_position_next = pos_cur;
    cr_pending_next     = 1'b0;
    if (is_end) begin
      status              = wsps_pkg::STATUS_END;
      match_position_next = '0;
    end else begin
      if (cr_cur) begin
        // LF must follow the CR, anything else drops the partial match
        if (data_byte == wsps_pkg::CH_LF) begin
          advance = 1'b1;
        end else begin
          match_position_next = '0;
        end
      end else if (pos_cur == '0) begin
        advance = (data_byte == pat_char);
      end else if (data_byte == pat_char || pat_char == wsps_pkg::CH_WILD) begin
        advance = 1'b1;
      end else if (pat_char == wsps_pkg::CH_LF && data_byte == wsps_pkg::CH_CR) begin
        cr_pending_next = 1'b1;
      end else begin
        match_position_next = '0;
      end
      if (advance) begin
        if (pos_inc >= len_eff) begin
          status              = wsps_pkg::STATUS_MATCHED;
          match_position_next = '0;
        end else begin
          match_position_next = pos_inc[POS_W-1:0];
        end
      end
    end
  end

  // Hold or advance the match state
  always_ff @(posedge clk) begin
    if (rst) begin
      match_position <= '0;
      cr_pending     <= 1'b0;
    end else if (step) begin
      match_position <= match_position_next;
      cr_pending     <= cr_pending_next;
    end
  end

endmodule

// File: rtl/wildcard_stream_pattern_search_top.sv
// ----------------------------------------------------------------------------
// wildcard_stream_pattern_search_top: streaming pattern search
// Scans a byte stream for a configured pattern with '?' and CR LF handling.
//
// Usage:
//   Input channel (in_valid/in_ready): one word per byte, data_byte plus
//   is_end, which marks end of stream and yields an end status.
//   Output channel (out_valid/out_ready): one status word per input word,
//   in order: 0 searching, 1 pattern matched on this byte, 2 end without
//   match. After a match or end the matcher re-arms.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0 pattern
//   characters, 1 pattern length) at the clock edge; write only while idle.
// Pipeline and throughput:
//   An accepted word is held and matched in the input register, then moves
//   to the output register. One word per cycle sustained while out_ready
//   is high; the match state update is a single compare and select per word.
// Reset and stalls:
//   rst clears the match state, both pipeline stages and the configuration
//   (pattern all zero, length 1). When out_ready is low the output word
//   holds, the input register fills, and in_ready drops until it drains.
// ----------------------------------------------------------------------------
module wildcard_stream_pattern_search_top #(
  parameter int MAX_PATTERN = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        is_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  wsps_pkg::pattern_cfg_t cfg;

  logic               in_reg_valid;
  logic [7:0]         in_reg_byte;
  logic               in_reg_end;
  logic               step;
  wsps_pkg::status_t  status_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chars  <= '0;
      cfg.length <= 4'd1;
    end else if (cfg_we) begin
      unique case (wsps_pkg::reg_index_t'(cfg_index))
        wsps_pkg::REG_PATTERN_CHARS:  cfg.chars  <= cfg_data;
        wsps_pkg::REG_PATTERN_LENGTH: cfg.length <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Move a word from input register to output register when there is room
  assign step     = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_reg_byte <= data_byte;
      in_reg_end  <= is_end;
    end
  end

  wsps_matcher #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_matcher (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .data_byte(in_reg_byte),
    .is_end   (in_reg_end),
    .cfg      (cfg),
    .status   (status_next)
  );

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      status <= status_next;
    end
  end

endmodule
